// ===== src/abd_pkg.sv =====
`default_nettype none

package abd_pkg;

    localparam int NUM_CLASSES_DEF    = 14;
    localparam int IMAGE_SIZE_DEF     = 640;
    localparam int SIG_TABLE_BITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;
    localparam int PROB_W      = 16;
    localparam int CLASS_W     = 4;
    localparam int ANCHOR_W    = 5;

    // element positions inside one cell
    localparam int POS_OBJ    = 4;
    localparam int CLASS_BASE = 5;

    // e^(-2^k / 256), Q30
    localparam longint unsigned EXPQ [12] = '{
        64'd1069555809, 64'd1065385892, 64'd1057094950, 64'd1040706175,
        64'd1008686831, 64'd947573892,  64'd836230833,  64'd651257336,
        64'd395007542,  64'd145315154,  64'd19666265,   64'd360201
    };

    // (w, h) per level and slot: level * 6 + slot * 2
    localparam logic [ANCHOR_W-1:0] ANCHORS [18] = '{
        5'd13, 5'd8,  5'd15, 5'd9,  5'd15, 5'd12,
        5'd19, 5'd15, 5'd19, 5'd17, 5'd23, 5'd19,
        5'd26, 5'd26, 5'd30, 5'd23, 5'd30, 5'd26
    };

    typedef struct packed {
        logic [PROB_W-1:0]  sx;
        logic [PROB_W-1:0]  sy;
        logic [PROB_W-1:0]  sw;
        logic [PROB_W-1:0]  sh;
        logic [PROB_W-1:0]  obj;
        logic [PROB_W-1:0]  best;
        logic [CLASS_W-1:0] cls;
        logic [1:0]         level;
        logic [1:0]         slot;
        logic [6:0]         col;
        logic [6:0]         row;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_EDGE
    } bk_state_t;

    // table entry k, evaluated at elaboration only
    function automatic logic [PROB_W-1:0] sig_entry(input int k, input int tb);
        int                step;
        int                v;
        longint unsigned   a;
        longint unsigned   e;
        longint unsigned   den;
        longint unsigned   num;
        longint unsigned   rem;
        longint unsigned   q;
        step = 1 << (12 - tb);
        v    = -2048 + k * step + (step >> 1);
        a    = (v < 0) ? longint'(-v) : longint'(v);
        e    = 64'd1 << 30;
        for (int i = 0; i < 12; i++)
        begin
            if (a[i])
            begin
                e = (e * EXPQ[i] + (64'd1 << 29)) >> 30;
            end
        end
        den = (64'd1 << 30) + e;
        num = (v >= 0) ? (64'd1 << 46) : (e << 16);
        num = num + (den >> 1);
        rem = 64'd0;
        q   = 64'd0;
        for (int i = 47; i >= 0; i--)
        begin
            rem = (rem << 1) | longint'(num[i]);
            if (rem >= den)
            begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        if (q > 64'd65535)
        begin
            q = 64'd65535;
        end
        return q[PROB_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/abd_sig_rom.sv =====
`default_nettype none

module abd_sig_rom #(
    parameter int SIG_TABLE_BITS = abd_pkg::SIG_TABLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [SIG_TABLE_BITS-1:0]     addr,
    output logic      [abd_pkg::PROB_W-1:0]    data
);

    localparam int DEPTH = 1 << SIG_TABLE_BITS;

    logic [abd_pkg::PROB_W-1:0] rom_w [DEPTH];
    logic [abd_pkg::PROB_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        localparam logic [abd_pkg::PROB_W-1:0] VAL = abd_pkg::sig_entry(k, SIG_TABLE_BITS);
        assign rom_w[k] = VAL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_w[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== src/abd_front.sv =====
`default_nettype none

module abd_front #(
    parameter int NUM_CLASSES    = abd_pkg::NUM_CLASSES_DEF,
    parameter int SIG_TABLE_BITS = abd_pkg::SIG_TABLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [abd_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire abd_pkg::q_status_t                q_status,
    output logic                                   push,
    output abd_pkg::job_t                          push_job
);

    localparam int POS_W = $clog2(NUM_CLASSES + abd_pkg::CLASS_BASE);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_CLASSES + abd_pkg::POS_OBJ);
    localparam logic [POS_W-1:0] OBJ_POS  = POS_W'(abd_pkg::POS_OBJ);
    localparam logic [POS_W-1:0] CLS_BASE = POS_W'(abd_pkg::CLASS_BASE);

    logic signed [15:0]            logit;
    logic signed [15:0]            clamped;
    logic [11:0]                   biased;
    logic                          accept;
    logic                          stall;
    logic                          fire;
    logic                          st1_last;
    logic [abd_pkg::PROB_W-1:0]    sig;

    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          st1_valid_reg, st1_valid_next;
    logic [POS_W-1:0]              st1_pos_reg;
    logic [1:0]                    st1_level_reg;
    logic [1:0]                    st1_slot_reg;
    logic [6:0]                    st1_col_reg;
    logic [6:0]                    st1_row_reg;

    logic [abd_pkg::PROB_W-1:0]    box_s_reg [4];
    logic [abd_pkg::PROB_W-1:0]    box_s_next [4];
    logic [abd_pkg::PROB_W-1:0]    obj_reg, obj_next;
    logic [abd_pkg::PROB_W-1:0]    best_reg, best_next;
    logic [abd_pkg::CLASS_W-1:0]   cls_reg, cls_next;

    assign logit = $signed(s_tdata[15:0]);

    always_comb
    begin
        priority if (logit < -16'sd2048)
        begin
            clamped = -16'sd2048;
        end
        else if (logit > 16'sd2047)
        begin
            clamped = 16'sd2047;
        end
        else
        begin
            clamped = logit;
        end
    end

    assign biased = clamped[11:0] ^ 12'h800;

    abd_sig_rom #(
        .SIG_TABLE_BITS (SIG_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (accept),
        .addr (biased[11 -: SIG_TABLE_BITS]),
        .data (sig)
    );

    assign st1_last = (st1_pos_reg == LAST_POS);
    assign stall    = st1_valid_reg && st1_last && q_status.full;
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;
    assign fire     = st1_valid_reg && !stall;

    always_comb
    begin
        pos_next       = pos_reg;
        st1_valid_next = st1_valid_reg;
        if (accept)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
        if (!stall)
        begin
            st1_valid_next = accept;
        end
    end

    always_comb
    begin
        box_s_next = box_s_reg;
        obj_next   = obj_reg;
        best_next  = best_reg;
        cls_next   = cls_reg;
        if (fire)
        begin
            priority if (st1_pos_reg < OBJ_POS)
            begin
                box_s_next[st1_pos_reg[1:0]] = sig;
            end
            else if (st1_pos_reg == OBJ_POS)
            begin
                obj_next  = sig;
                best_next = '0;
                cls_next  = '0;
            end
            else if (sig > best_reg)
            begin
                best_next = sig;
                cls_next  = abd_pkg::CLASS_W'(st1_pos_reg - CLS_BASE);
            end
        end
    end

    assign push = fire && st1_last;

    always_comb
    begin
        push_job.sx    = box_s_reg[0];
        push_job.sy    = box_s_reg[1];
        push_job.sw    = box_s_reg[2];
        push_job.sh    = box_s_reg[3];
        push_job.obj   = obj_reg;
        push_job.best  = best_next;
        push_job.cls   = cls_next;
        push_job.level = st1_level_reg;
        push_job.slot  = st1_slot_reg;
        push_job.col   = st1_col_reg;
        push_job.row   = st1_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            st1_valid_reg <= 1'b0;
            obj_reg       <= '0;
            best_reg      <= '0;
            cls_reg       <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            st1_valid_reg <= st1_valid_next;
            obj_reg       <= obj_next;
            best_reg      <= best_next;
            cls_reg       <= cls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_s_reg <= box_s_next;
        if (accept)
        begin
            st1_pos_reg   <= pos_reg;
            st1_level_reg <= s_tdata[17:16];
            st1_slot_reg  <= s_tdata[19:18];
            st1_col_reg   <= s_tdata[26:20];
            st1_row_reg   <= s_tdata[33:27];
        end
    end

endmodule

`default_nettype wire

// ===== src/abd_fifo.sv =====
`default_nettype none

module abd_fifo #(
    parameter int DEPTH = abd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire abd_pkg::job_t      push_job,
    input  wire logic               pop,
    output abd_pkg::job_t           pop_job,
    output abd_pkg::q_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    abd_pkg::job_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/abd_back.sv =====
`default_nettype none

module abd_back #(
    parameter int IMAGE_SIZE = abd_pkg::IMAGE_SIZE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [abd_pkg::PROB_W-1:0]         min_conf,
    input  wire abd_pkg::q_status_t                 q_status,
    input  wire abd_pkg::job_t                      pop_job,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [abd_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int GRID0 = IMAGE_SIZE / 8;
    localparam int GRID1 = IMAGE_SIZE / 16;
    localparam int GRID2 = IMAGE_SIZE / 32;

    abd_pkg::bk_state_t state_reg, state_next;

    abd_pkg::job_t                  job_reg;
    logic [31:0]                    sqw_reg;
    logic [31:0]                    sqh_reg;
    logic [31:0]                    prod_reg;
    logic [1:0]                     lv_reg;
    logic [6:0]                     colc_reg;
    logic [6:0]                     rowc_reg;
    logic [abd_pkg::ANCHOR_W-1:0]   anc_w_reg;
    logic [abd_pkg::ANCHOR_W-1:0]   anc_h_reg;
    logic [15:0]                    w4_reg;
    logic [15:0]                    h4_reg;
    logic [15:0]                    conf_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [15:0]                    left_reg;
    logic [15:0]                    top_reg;
    logic [15:0]                    width_reg;
    logic [15:0]                    height_reg;
    logic [abd_pkg::CLASS_W-1:0]    cls_out_reg;
    logic [15:0]                    conf_out_reg;

    logic                           out_free;
    logic                           load_out;
    logic [1:0]                     lv_c;
    logic [1:0]                     slot_c;
    logic [4:0]                     anc_idx;
    logic [7:0]                     grid_m1;
    logic [36:0]                    tw;
    logic [36:0]                    th;
    logic [11:0]                    w4_c;
    logic [11:0]                    h4_c;
    logic [16:0]                    conf_r;
    logic [15:0]                    conf_c;
    logic                           pass;

    function automatic logic [15:0] edge_q4(
        input logic [15:0] s,
        input logic [6:0]  grid_idx,
        input logic [1:0]  lv,
        input logic [15:0] size4
    );
        logic signed [31:0] c;
        logic signed [31:0] e;
        logic signed [19:0] q;
        c = $signed({15'b0, s, 1'b0}) - 32'sd32768 + $signed({9'b0, grid_idx, 16'b0});
        c = c <<< (32'(lv) + 32'd3);
        e = c - $signed({5'b0, size4, 11'b0}) + 32'sd2048;
        q = 20'(e >>> 12);
        if (q < -20'sd32768)
        begin
            return 16'h8000;
        end
        else if (q > 20'sd32767)
        begin
            return 16'h7FFF;
        end
        return q[15:0];
    endfunction

    // MUL stage selections
    assign lv_c    = (job_reg.level == 2'd3) ? 2'd2 : job_reg.level;
    assign slot_c  = (job_reg.slot == 2'd3) ? 2'd2 : job_reg.slot;
    assign anc_idx = 5'(lv_c) * 5'd6 + {2'b0, slot_c, 1'b0};

    always_comb
    begin
        unique case (lv_c)
            2'd0:    grid_m1 = 8'(GRID0 - 1);
            2'd1:    grid_m1 = 8'(GRID1 - 1);
            default: grid_m1 = 8'(GRID2 - 1);
        endcase
    end

    // SCALE stage
    assign tw     = sqw_reg * anc_w_reg;
    assign th     = sqh_reg * anc_h_reg;
    assign w4_c   = 12'((tw + 37'd33554432) >> 26);
    assign h4_c   = 12'((th + 37'd33554432) >> 26);
    assign conf_r = 17'((33'(prod_reg) + 33'd32768) >> 16);
    assign conf_c = conf_r[16] ? 16'hFFFF : conf_r[15:0];
    assign pass   = (job_reg.obj >= min_conf) && (conf_c >= min_conf);

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            abd_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = abd_pkg::BK_MUL;
                end
            end
            abd_pkg::BK_MUL:
            begin
                state_next = abd_pkg::BK_SCALE;
            end
            abd_pkg::BK_SCALE:
            begin
                state_next = pass ? abd_pkg::BK_EDGE : abd_pkg::BK_IDLE;
            end
            abd_pkg::BK_EDGE:
            begin
                if (out_free)
                begin
                    state_next = abd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = abd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            abd_pkg::BK_IDLE:  pop      = !q_status.empty;
            abd_pkg::BK_EDGE:  load_out = out_free;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abd_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
        end
        if (state_reg == abd_pkg::BK_MUL)
        begin
            sqw_reg   <= job_reg.sw * job_reg.sw;
            sqh_reg   <= job_reg.sh * job_reg.sh;
            prod_reg  <= job_reg.obj * job_reg.best;
            lv_reg    <= lv_c;
            colc_reg  <= ({1'b0, job_reg.col} > grid_m1) ? grid_m1[6:0] : job_reg.col;
            rowc_reg  <= ({1'b0, job_reg.row} > grid_m1) ? grid_m1[6:0] : job_reg.row;
            anc_w_reg <= abd_pkg::ANCHORS[anc_idx];
            anc_h_reg <= abd_pkg::ANCHORS[anc_idx + 5'd1];
        end
        if (state_reg == abd_pkg::BK_SCALE)
        begin
            w4_reg   <= {4'b0, w4_c};
            h4_reg   <= {4'b0, h4_c};
            conf_reg <= conf_c;
        end
        if (load_out)
        begin
            left_reg     <= edge_q4(job_reg.sx, colc_reg, lv_reg, w4_reg);
            top_reg      <= edge_q4(job_reg.sy, rowc_reg, lv_reg, h4_reg);
            width_reg    <= w4_reg;
            height_reg   <= h4_reg;
            cls_out_reg  <= job_reg.cls;
            conf_out_reg <= conf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, conf_out_reg, cls_out_reg, height_reg, width_reg,
                       top_reg, left_reg};

endmodule

`default_nettype wire

// ===== src/anchor_box_decode_filter_core.sv =====
`default_nettype none

// Decodes detector-head logits into at most one box per anchor cell. Logits of a cell
// arrive one per beat in the order x, y, w, h, objectness, then NUM_CLASSES class logits,
// and are taken back to back, one beat per cycle while the input is not stalled. The front
// end looks each logit up in a registered sigmoid ROM and keeps the running class argmax;
// on the cell's last beat it queues a decode job. The back end takes one job at a time
// through the queue pop, two multiply stages and the edge stage that loads the output
// register, and drops a rejected job after the second multiply stage. The input stalls
// only while the two-entry job queue is full and a cell's last beat is waiting, which takes
// the output held back for close to four cells in a row. Cells whose objectness or
// confidence falls below the threshold give no output beat. The threshold (Q0.16, reset
// one half) is written on the cfg channel.
module anchor_box_decode_filter_core #(
    parameter int NUM_CLASSES    = abd_pkg::NUM_CLASSES_DEF,
    parameter int IMAGE_SIZE     = abd_pkg::IMAGE_SIZE_DEF,
    parameter int SIG_TABLE_BITS = abd_pkg::SIG_TABLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [abd_pkg::PROB_W-1:0]         cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // logit[15:0], level[17:16], anchor_slot[19:18], col[26:20], row[33:27]
    input  wire logic [abd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // box_left[15:0], box_top[31:16], box_width[47:32], box_height[63:48],
    // class_id[67:64], confidence[83:68]
    output logic [abd_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    logic [abd_pkg::PROB_W-1:0]   thr_reg, thr_next;
    logic                         push;
    logic                         pop;
    abd_pkg::job_t                push_job;
    abd_pkg::job_t                pop_job;
    abd_pkg::q_status_t           q_status;

    assign cfg_ready = 1'b1;
    assign thr_next  = (cfg_valid && cfg_ready) ? cfg_data : thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'h8000;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    abd_front #(
        .NUM_CLASSES    (NUM_CLASSES),
        .SIG_TABLE_BITS (SIG_TABLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    abd_fifo #(
        .DEPTH (abd_pkg::QUEUE_DEPTH_DEF)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    abd_back #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .min_conf (thr_reg),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n) !s_tready |-> q_status.full
    ) else $error("input stalled with room in the job queue");

    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n) push |-> !q_status.full
    ) else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty
    ) else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ===== bench/tb_anchor_box_decode_filter_core.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [3:0]         cls;
    logic [15:0]        conf;
} decoded_box_t;

class box_predictor;
    localparam int CELL_LEN = abd_pkg::NUM_CLASSES_DEF + abd_pkg::CLASS_BASE;

    longint unsigned    exp_q30 [12];
    longint unsigned    anchor_dim [18];
    logic [15:0]        sig_rom [1024];
    logic [15:0]        threshold;
    int unsigned        logit_pos;
    logic signed [15:0] geom_logit [4];
    logic [15:0]        obj_prob;
    logic [15:0]        top_prob;
    logic [3:0]         top_class;
    decoded_box_t       boxes_due [$];
    int                 errors;
    int                 logits_seen;
    int                 boxes_checked;

    function new();
        exp_q30 = '{64'd1069555809, 64'd1065385892, 64'd1057094950, 64'd1040706175,
                    64'd1008686831, 64'd947573892,  64'd836230833,  64'd651257336,
                    64'd395007542,  64'd145315154,  64'd19666265,   64'd360201};
        anchor_dim = '{13, 8, 15, 9, 15, 12, 19, 15, 19, 17, 23, 19, 26, 26, 30, 23, 30, 26};
        for (int k = 0; k < 1024; k++)
        begin
            sig_rom[k] = sig_point(-2048 + k * 4 + 2);
        end
        threshold     = 16'd32768;
        logit_pos     = 0;
        obj_prob      = '0;
        top_prob      = '0;
        top_class     = '0;
        errors        = 0;
        logits_seen   = 0;
        boxes_checked = 0;
    endfunction

    function logic [15:0] sig_point(int v);
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned p;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        e   = 64'd1 << 30;
        for (int k = 0; k < 12; k++)
        begin
            if (mag[k])
            begin
                e = (e * exp_q30[k] + (64'd1 << 29)) >> 30;
            end
        end
        den = (64'd1 << 30) + e;
        num = (v >= 0) ? (64'd1 << 46) : (e << 16);
        p   = (num + den / 2) / den;
        return (p > 64'd65535) ? 16'hFFFF : p[15:0];
    endfunction

    function logic [15:0] sig_lookup(logic signed [15:0] l);
        int li;
        li = l;
        if (li < -2048)
        begin
            li = -2048;
        end
        if (li > 2047)
        begin
            li = 2047;
        end
        return sig_rom[(li + 2048) >> 2];
    endfunction

    function longint unsigned side_q4(logic [15:0] s, longint unsigned anchor);
        longint unsigned sv;
        longint unsigned v;
        sv = s;
        v  = (4 * sv * sv * anchor + (64'd1 << 27)) >> 28;
        return (v > 64'd65535) ? 64'd65535 : v;
    endfunction

    function logic [15:0] corner_q4(logic [15:0] s, int unsigned grid_idx,
                                    int unsigned stride, longint unsigned size4);
        longint sv;
        longint c16;
        longint q;
        sv  = s;
        c16 = (2 * sv - 32768 + 65536 * longint'(grid_idx)) * longint'(stride);
        q   = (c16 - 2048 * longint'(size4) + 2048) >>> 12;
        if (q < -32768)
        begin
            q = -32768;
        end
        if (q > 32767)
        begin
            q = 32767;
        end
        return q[15:0];
    endfunction

    function void take_logit(logic [abd_pkg::IN_TDATA_W-1:0] beat);
        logic signed [15:0] l;
        logic [15:0]        s;
        longint unsigned    conf;
        int unsigned        lv;
        int unsigned        slot;
        int unsigned        stride;
        int unsigned        grid;
        int unsigned        col;
        int unsigned        row;
        longint unsigned    w4;
        longint unsigned    h4;
        decoded_box_t       box;
        l = beat[15:0];
        s = sig_lookup(l);
        logits_seen++;
        if (logit_pos < abd_pkg::POS_OBJ)
        begin
            geom_logit[logit_pos] = l;
        end
        else if (logit_pos == abd_pkg::POS_OBJ)
        begin
            obj_prob  = s;
            top_prob  = '0;
            top_class = '0;
        end
        else if (s > top_prob)
        begin
            top_prob  = s;
            top_class = 4'(logit_pos - abd_pkg::CLASS_BASE);
        end
        if (logit_pos < CELL_LEN - 1)
        begin
            logit_pos++;
            return;
        end
        logit_pos = 0;
        if (obj_prob < threshold)
        begin
            return;
        end
        conf = (longint'(obj_prob) * longint'(top_prob) + 32768) >> 16;
        if (conf > 65535)
        begin
            conf = 65535;
        end
        if (conf < threshold)
        begin
            return;
        end
        lv     = (beat[17:16] > 2) ? 2 : beat[17:16];
        slot   = (beat[19:18] > 2) ? 2 : beat[19:18];
        stride = 8 << lv;
        grid   = abd_pkg::IMAGE_SIZE_DEF / stride;
        col    = (beat[26:20] >= grid) ? grid - 1 : beat[26:20];
        row    = (beat[33:27] >= grid) ? grid - 1 : beat[33:27];
        w4     = side_q4(sig_lookup(geom_logit[2]), anchor_dim[lv * 6 + slot * 2]);
        h4     = side_q4(sig_lookup(geom_logit[3]), anchor_dim[lv * 6 + slot * 2 + 1]);
        box.left   = corner_q4(sig_lookup(geom_logit[0]), col, stride, w4);
        box.top    = corner_q4(sig_lookup(geom_logit[1]), row, stride, h4);
        box.width  = w4[15:0];
        box.height = h4[15:0];
        box.cls    = top_class;
        box.conf   = conf[15:0];
        boxes_due  = {boxes_due, box};
    endfunction

    function void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_box(logic [abd_pkg::OUT_TDATA_W-1:0] beat);
        decoded_box_t got;
        decoded_box_t want;
        got.left   = beat[15:0];
        got.top    = beat[31:16];
        got.width  = beat[47:32];
        got.height = beat[63:48];
        got.cls    = beat[67:64];
        got.conf   = beat[83:68];
        if (boxes_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected box, expected none, got %p", $time, got);
            return;
        end
        want = boxes_due.pop_front();
        boxes_checked++;
        compare_field("box_left", want.left, got.left);
        compare_field("box_top", want.top, got.top);
        compare_field("box_width", want.width, got.width);
        compare_field("box_height", want.height, got.height);
        compare_field("class_id", want.cls, got.cls);
        compare_field("confidence", want.conf, got.conf);
    endfunction
endclass

module tb_anchor_box_decode_filter_core;
    localparam int CELL_LEN   = abd_pkg::NUM_CLASSES_DEF + abd_pkg::CLASS_BASE;
    localparam int N_PHASES   = 7;
    localparam int SETTLE     = 20;
    localparam int QUIET_MAX  = 4000;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [abd_pkg::PROB_W-1:0]        cfg_data  = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [abd_pkg::IN_TDATA_W-1:0]    s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [abd_pkg::OUT_TDATA_W-1:0]   m_tdata;

    box_predictor sb;
    logic [15:0]  cell_buf [CELL_LEN];
    bit           calm      = 1'b0;
    int           gap_pct   = 0;
    int           stall_pct = 0;
    int           stall_left = 0;
    int           quiet     = 0;
    int           cells_sent = 0;

    anchor_box_decode_filter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output stalls in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            m_tready   = 1'b0;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_box(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_MAX)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, QUIET_MAX);
            $display("tb_anchor_box_decode_filter_core: done, errors");
            $finish;
        end
    end

    function automatic logic [15:0] rand_logit();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            3:       return 16'(int'($urandom_range(0, 800)) - 400);
            default: return 16'(int'($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    task automatic idle_sender(input int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_logit(input logic [abd_pkg::IN_TDATA_W-1:0] beat);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = beat;
        do @(posedge clk); while (!s_tready);
        sb.take_logit(beat);
    endtask

    // side fields matter only on the last beat of a cell
    task automatic send_cell(input logic [1:0] lvl, input logic [1:0] slot,
                             input logic [6:0] col, input logic [6:0] row);
        logic [abd_pkg::IN_TDATA_W-1:0] beat;
        for (int i = 0; i < CELL_LEN; i++)
        begin
            if (!calm && $urandom_range(0, 99) < gap_pct)
            begin
                idle_sender($urandom_range(1, 6));
            end
            if (i == CELL_LEN - 1)
            begin
                beat = {6'b0, row, col, slot, lvl, cell_buf[i]};
            end
            else
            begin
                beat = {6'b0, 7'($urandom), 7'($urandom), 2'($urandom), 2'($urandom),
                        cell_buf[i]};
            end
            send_logit(beat);
        end
        cells_sent++;
    endtask

    task automatic random_cell();
        int favored;
        int grid_cap;
        favored  = $urandom_range(0, abd_pkg::NUM_CLASSES_DEF - 1);
        grid_cap = ($urandom_range(0, 4) == 0) ? 127 : 79;
        if (!calm)
        begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
        end
        for (int k = 0; k < abd_pkg::POS_OBJ; k++)
        begin
            cell_buf[k] = rand_logit();
        end
        cell_buf[abd_pkg::POS_OBJ] = ($urandom_range(0, 2) != 0) ?
                                     16'($urandom_range(0, 2047)) : rand_logit();
        for (int c = 0; c < abd_pkg::NUM_CLASSES_DEF; c++)
        begin
            cell_buf[abd_pkg::CLASS_BASE + c] = rand_logit();
            if (c == favored && $urandom_range(0, 1) == 1)
            begin
                cell_buf[abd_pkg::CLASS_BASE + c] = 16'($urandom_range(256, 2047));
            end
            if (c > 0 && $urandom_range(0, 7) == 0)
            begin
                cell_buf[abd_pkg::CLASS_BASE + c] =
                    cell_buf[abd_pkg::CLASS_BASE + $urandom_range(0, c - 1)];
            end
        end
        send_cell(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  7'($urandom_range(0, grid_cap)), 7'($urandom_range(0, grid_cap)));
    endtask

    task automatic drain_boxes();
        idle_sender(1);
        while (sb.boxes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        sb.threshold = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int phase_thr [N_PHASES];
        int phase_cells [N_PHASES];
        phase_thr   = '{32768, 0, 65535, 0, 1, 40000, 32768};
        phase_cells = '{10, 15, 10, 15, 10, 12, 13};
        phase_thr[3] = $urandom_range(0, 65535);
        sb = new;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // saturated logits, class tie, level and slot three, cell past the grid
        gap_pct = 10;
        stall_pct = 10;
        cell_buf[0] = 16'h8000;
        cell_buf[1] = 16'h7FFF;
        cell_buf[2] = 16'h7FFF;
        cell_buf[3] = 16'h8000;
        cell_buf[4] = 16'h7FFF;
        for (int c = 0; c < abd_pkg::NUM_CLASSES_DEF; c++)
        begin
            cell_buf[abd_pkg::CLASS_BASE + c] = 16'h0100;
        end
        send_cell(2'd3, 2'd3, 7'd127, 7'd127);

        // opposite extremes, last class wins, origin cell
        cell_buf[0] = 16'h7FFF;
        cell_buf[1] = 16'h8000;
        cell_buf[2] = 16'h8000;
        cell_buf[3] = 16'h7FFF;
        cell_buf[4] = 16'h0400;
        for (int c = 0; c < abd_pkg::NUM_CLASSES_DEF; c++)
        begin
            cell_buf[abd_pkg::CLASS_BASE + c] = 16'(-2048 + c * 300);
        end
        cell_buf[abd_pkg::CLASS_BASE] = 16'h8000;
        cell_buf[CELL_LEN - 1] = 16'h7FFF;
        send_cell(2'd0, 2'd0, 7'd0, 7'd0);

        // objectness below threshold: no box
        for (int k = 0; k < CELL_LEN; k++)
        begin
            cell_buf[k] = 16'h0000;
        end
        cell_buf[4] = 16'hFF00;
        send_cell(2'd1, 2'd2, 7'd40, 7'd39);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_boxes();
                write_threshold(16'(phase_thr[p]));
            end
            if (p == N_PHASES - 1)
            begin
                calm      = 1'b1;
                gap_pct   = 0;
                stall_pct = 0;
            end
            repeat (phase_cells[p]) random_cell();
        end
        drain_boxes();

        $display("covered %0d cells (%0d logits) over %0d threshold settings;", cells_sent,
                 sb.logits_seen, N_PHASES);
        $display("%0d boxes checked, %0d mismatches", sb.boxes_checked, sb.errors);
        if (sb.errors == 0)
        begin
            $display("tb_anchor_box_decode_filter_core: done, clean");
        end
        else
        begin
            $display("tb_anchor_box_decode_filter_core: done, errors");
        end
        $finish;
    end
endmodule
